// File: src/assert_macros.svh
// assertion helpers used by the rate meter divider
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ERM_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define ERM_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/erm_pkg.sv
// ----------------------------------------------------------------------------
// erm_pkg
// Types and constants shared by the event rate meter modules.
// ----------------------------------------------------------------------------
package erm_pkg;

  localparam logic [19:0] US_PER_S  = 20'd1000000;
  localparam logic [47:0] RATE_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [32:0] TIMER_MAX = 33'h1_FFFF_FFFF;

  localparam logic [31:0] WINDOW_RESET = 32'd1000000;
  localparam logic [16:0] WEIGHT_RESET = 17'd6554;

  localparam logic [1:0] CFG_IDX_WINDOW = 2'd0;
  localparam logic [1:0] CFG_IDX_RISE   = 2'd1;
  localparam logic [1:0] CFG_IDX_FALL   = 2'd2;

  typedef struct packed {
    logic [31:0] elapsed_us;
    logic [31:0] event_count;
  } in_item_t;

  typedef struct packed {
    logic [47:0] sample_rate;
    logic [47:0] window_rate;
    logic [63:0] window_events;
    logic        window_done;
    logic [47:0] mean_rate;
    logic [47:0] smoothed_rate;
    logic [63:0] total_events;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE_LO,
    ST_RATE_HI,
    ST_RATE_GO,
    ST_RATE_WAIT,
    ST_WIN_CHK,
    ST_EMA_W,
    ST_EMA_A,
    ST_EMA_B,
    ST_EMA_C,
    ST_FINISH
  } ctrl_state_e;

  typedef enum logic [1:0] {
    SRC_INST,
    SRC_WIN,
    SRC_MEAN
  } rate_src_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_RATE_LO,
    MUL_RATE_HI,
    MUL_EMA_A,
    MUL_EMA_B
  } mul_op_e;

  typedef struct packed {
    logic      load;
    logic      win_close;
    rate_src_e src;
    mul_op_e   mul;
    logic      div_start;
    logic      div_store;
    logic      pick_weight;
    logic      ema_store;
    logic      publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic win_hit;
    logic out_busy;
  } dp_status_t;

endpackage

// File: src/erm_div.sv
// ----------------------------------------------------------------------------
// erm_div
// Restoring divider, one quotient bit per cycle, quotient saturated to 48 bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module erm_div import erm_pkg::*; #(
  parameter int NUM_W = 100
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [63:0]      den_i,
  output logic             done_o,
  output logic [47:0]      quot_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [63:0]      den_q;
  logic [63:0]      rem_q;
  logic [47:0]      q_q;
  logic             sat_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [64:0] rem_sh;
  logic [64:0] rem_sub;
  logic        ge;
  logic [48:0] q_sh;

  always_comb begin
    rem_sh  = {rem_q, num_q[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
    q_sh    = {q_q, ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0;
      den_q <= '0;
      rem_q <= '0;
      q_q   <= '0;
      sat_q <= 1'b0;
    end else if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      q_q   <= '0;
      sat_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= ge ? rem_sub[63:0] : rem_sh[63:0];
      // once past 48 bits the quotient sticks at the top
      if (sat_q || q_sh[48]) begin
        q_q   <= RATE_MAX;
        sat_q <= 1'b1;
      end else begin
        q_q <= q_sh[47:0];
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

  `ERM_CHECK_NEXT(a_start_busy, start_i, busy_q, "divider did not start")
  `ERM_CHECK(a_done_idle, !done_q || !busy_q, "divider done while busy")
  `ERM_CHECK(a_sat_max, busy_q || !sat_q || (q_q == RATE_MAX), "saturated quotient not at max")

endmodule

// File: src/erm_ctrl.sv
// ----------------------------------------------------------------------------
// erm_ctrl
// Sequencer: instant rate, optional window rate, mean rate, then the average.
// ----------------------------------------------------------------------------
module erm_ctrl import erm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  rate_src_e   src_q, src_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      src_q   <= SRC_INST;
    end else begin
      state_q <= state_d;
      src_q   <= src_d;
    end
  end

  always_comb begin
    state_d = state_q;
    src_d   = src_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RATE_LO;
          src_d   = SRC_INST;
        end
      end
      ST_RATE_LO:   state_d = ST_RATE_HI;
      ST_RATE_HI:   state_d = ST_RATE_GO;
      ST_RATE_GO:   state_d = ST_RATE_WAIT;
      ST_RATE_WAIT: begin
        if (status_i.div_done) begin
          case (src_q)
            SRC_INST: state_d = ST_WIN_CHK;
            SRC_WIN: begin
              state_d = ST_RATE_LO;
              src_d   = SRC_MEAN;
            end
            default:  state_d = ST_EMA_W;
          endcase
        end
      end
      ST_WIN_CHK: begin
        state_d = ST_RATE_LO;
        src_d   = status_i.win_hit ? SRC_WIN : SRC_MEAN;
      end
      ST_EMA_W: state_d = ST_EMA_A;
      ST_EMA_A: state_d = ST_EMA_B;
      ST_EMA_B: state_d = ST_EMA_C;
      ST_EMA_C: state_d = ST_FINISH;
      ST_FINISH: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    cmd_o.src = src_q;
    cmd_o.mul = MUL_NONE;
    case (state_q)
      ST_IDLE:      cmd_o.load = in_valid_i;
      ST_RATE_LO:   cmd_o.mul = MUL_RATE_LO;
      ST_RATE_HI:   cmd_o.mul = MUL_RATE_HI;
      ST_RATE_GO:   cmd_o.div_start = 1'b1;
      ST_RATE_WAIT: cmd_o.div_store = status_i.div_done;
      ST_WIN_CHK:   cmd_o.win_close = status_i.win_hit;
      ST_EMA_W:     cmd_o.pick_weight = 1'b1;
      ST_EMA_A:     cmd_o.mul = MUL_EMA_A;
      ST_EMA_B:     cmd_o.mul = MUL_EMA_B;
      ST_EMA_C:     cmd_o.ema_store = 1'b1;
      ST_FINISH:    cmd_o.publish = !status_i.out_busy;
      default:      cmd_o.load = 1'b0;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// File: src/erm_datapath.sv
// ----------------------------------------------------------------------------
// erm_datapath
// Totals, window timer, shared multiplier and accumulator, result register.
// ----------------------------------------------------------------------------
module erm_datapath import erm_pkg::*; #(
  parameter int RATE_FRAC_BITS   = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  output dp_status_t  status_o,
  input  in_item_t    in_item_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  localparam int ACC_W = 84;
  localparam int NUM_W = ACC_W + RATE_FRAC_BITS;
  localparam int WW    = (WEIGHT_FRAC_BITS + 1 > 17) ? WEIGHT_FRAC_BITS + 1 : 17;
  localparam int MB    = (WW > 20) ? WW : 20;
  localparam logic [WW-1:0]    ONE  = WW'(1) << WEIGHT_FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (WEIGHT_FRAC_BITS - 1);

  logic [31:0] interval_q;
  logic [16:0] rise_q, fall_q;
  logic [63:0] total_count_q, total_time_q, start_q, last_events_q;
  logic [32:0] timer_q, win_den_q;
  logic [47:0] last_rate_q, avg_q, inst_q, mean_q;
  logic        done_q, out_valid_q;
  logic [31:0] events_q, elapsed_q;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [WW-1:0]    w_q;
  out_item_t        out_q;

  logic [63:0]      rate_num, rate_den;
  logic [47:0]      mul_a;
  logic [MB-1:0]    mul_b;
  logic [47+MB:0]   prod;
  logic [33:0]      timer_sum;
  logic [16:0]      w_pick;
  logic             div_done;
  logic [47:0]      quot;
  logic [47:0]      rate_val;

  always_comb begin
    case (cmd_i.src)
      SRC_INST: begin
        rate_num = {32'd0, events_q};
        rate_den = {32'd0, elapsed_q};
      end
      SRC_WIN: begin
        rate_num = last_events_q;
        rate_den = {31'd0, win_den_q};
      end
      default: begin
        rate_num = total_count_q;
        rate_den = total_time_q;
      end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul)
      MUL_RATE_LO: begin
        mul_a = {16'd0, rate_num[31:0]};
        mul_b = MB'(US_PER_S);
      end
      MUL_RATE_HI: begin
        mul_a = {16'd0, rate_num[63:32]};
        mul_b = MB'(US_PER_S);
      end
      MUL_EMA_A: begin
        mul_a = inst_q;
        mul_b = MB'(w_q);
      end
      MUL_EMA_B: begin
        mul_a = avg_q;
        mul_b = MB'(ONE - w_q);
      end
      default: mul_a = '0;
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    case (cmd_i.mul)
      MUL_RATE_LO: acc_d = ACC_W'(prod);
      MUL_RATE_HI: acc_d = acc_q + (ACC_W'(prod) << 32);
      MUL_EMA_A:   acc_d = ACC_W'(prod);
      MUL_EMA_B:   acc_d = acc_q + ACC_W'(prod) + HALF;
      default:     acc_d = acc_q;
    endcase
  end

  erm_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (NUM_W'(acc_q) << RATE_FRAC_BITS),
    .den_i   (rate_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // a zero time gives a zero rate
  assign rate_val  = (rate_den == 64'd0) ? 48'd0 : quot;
  assign timer_sum = {1'b0, timer_q} + {2'b00, in_item_i.elapsed_us};
  assign w_pick    = (inst_q > avg_q) ? rise_q : fall_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q    <= WINDOW_RESET;
      rise_q        <= WEIGHT_RESET;
      fall_q        <= WEIGHT_RESET;
      total_count_q <= '0;
      total_time_q  <= '0;
      timer_q       <= '0;
      start_q       <= '0;
      last_events_q <= '0;
      last_rate_q   <= '0;
      avg_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IDX_WINDOW: interval_q <= cfg_data_i;
          CFG_IDX_RISE:   rise_q <= cfg_data_i[16:0];
          CFG_IDX_FALL:   fall_q <= cfg_data_i[16:0];
          default:        interval_q <= interval_q;
        endcase
      end
      if (cmd_i.load) begin
        total_count_q <= total_count_q + {32'd0, in_item_i.event_count};
        total_time_q  <= total_time_q + {32'd0, in_item_i.elapsed_us};
        timer_q       <= timer_sum[33] ? TIMER_MAX : timer_sum[32:0];
      end
      if (cmd_i.win_close) begin
        last_events_q <= total_count_q - start_q;
        start_q       <= total_count_q;
        timer_q       <= timer_q - {1'b0, interval_q};
      end
      if (cmd_i.div_store && cmd_i.src == SRC_WIN) begin
        last_rate_q <= rate_val;
      end
      if (cmd_i.ema_store) begin
        avg_q <= acc_q[WEIGHT_FRAC_BITS +: 48];
      end
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.load) begin
      events_q  <= in_item_i.event_count;
      elapsed_q <= in_item_i.elapsed_us;
      done_q    <= 1'b0;
    end
    if (cmd_i.win_close) begin
      win_den_q <= timer_q;
      done_q    <= 1'b1;
    end
    if (cmd_i.div_store && cmd_i.src == SRC_INST) begin
      inst_q <= rate_val;
    end
    if (cmd_i.div_store && cmd_i.src == SRC_MEAN) begin
      mean_q <= rate_val;
    end
    if (cmd_i.pick_weight) begin
      w_q <= (WW'(w_pick) > ONE) ? ONE : WW'(w_pick);
    end
    if (cmd_i.publish) begin
      out_q.sample_rate   <= inst_q;
      out_q.window_rate   <= last_rate_q;
      out_q.window_events <= last_events_q;
      out_q.window_done   <= done_q;
      out_q.mean_rate     <= mean_q;
      out_q.smoothed_rate <= avg_q;
      out_q.total_events  <= total_count_q;
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.win_hit  = (timer_q >= {1'b0, interval_q});
  assign status_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: src/event_rate_meter_smoothed.sv
// ----------------------------------------------------------------------------
// event_rate_meter_smoothed
// Instant, windowed, mean and asymmetrically smoothed event rates.
// ----------------------------------------------------------------------------
// One item at a time. Each item runs two or three rate divisions in turn on a
// single restoring divider that yields one quotient bit per cycle over
// N = 84 + RATE_FRAC_BITS numerator bits, plus multiply and averaging steps
// on one shared multiplier; the third division runs only when the item closes
// a window. The finished result sits in an output register until taken.
module event_rate_meter_smoothed import erm_pkg::*; #(
  parameter int RATE_FRAC_BITS   = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  erm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  erm_datapath #(
    .RATE_FRAC_BITS   (RATE_FRAC_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: tb/tb_event_rate_meter_smoothed.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_event_rate_meter_smoothed
// Self-checking bench for the smoothed event rate meter. A bit-exact
// predictor tracks totals, the window timer and the moving average, and each
// result is compared field by field against it. Bursty input, patterned
// output stalls and one long output hold-off run across several register
// settings.
// ----------------------------------------------------------------------------
module tb_event_rate_meter_smoothed;
  import erm_pkg::*;

  localparam logic [1:0]   CFG_IDX_NONE = 2'd3;
  localparam int           WATCHDOG_MAX = 20000;
  localparam logic [127:0] W_ONE        = 128'd65536;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;

  event_rate_meter_smoothed u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // predictor copy of registers and state
  logic [31:0] win_len_us;
  logic [16:0] up_weight;
  logic [16:0] down_weight;
  logic [63:0] sum_events;
  logic [63:0] sum_time_us;
  logic [32:0] win_timer;
  logic [63:0] win_base;
  logic [47:0] win_rate_q;
  logic [63:0] win_events_q;
  logic [47:0] ema_rate;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        errors;
  int        results_seen;
  int        idle_cycles;
  int        gap_left;
  int        burst_left;
  int        hold_left;
  bit        hold_done;
  int        cyc;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic logic [47:0] rate_fix(logic [63:0] num, logic [63:0] den);
    logic [127:0] prod;
    logic [127:0] quo;
    if (den == 64'd0) return 48'd0;
    prod = ({64'd0, num} * 128'd1000000) << 16;
    quo  = prod / {64'd0, den};
    return (quo > {80'd0, RATE_MAX}) ? RATE_MAX : quo[47:0];
  endfunction

  function automatic out_item_t meter_step(in_item_t it);
    out_item_t    r;
    logic [47:0]  inst;
    logic [33:0]  tsum;
    logic [127:0] w;
    logic [127:0] acc;
    r.window_done = 1'b0;
    inst = (it.event_count != 0 && it.elapsed_us != 0) ?
           rate_fix({32'd0, it.event_count}, {32'd0, it.elapsed_us}) : 48'd0;
    sum_events  = sum_events + it.event_count;
    sum_time_us = sum_time_us + it.elapsed_us;
    tsum = {1'b0, win_timer} + it.elapsed_us;
    win_timer = (tsum > {1'b0, TIMER_MAX}) ? TIMER_MAX : tsum[32:0];
    if (win_timer >= {1'b0, win_len_us}) begin
      win_events_q = sum_events - win_base;
      win_rate_q   = rate_fix(win_events_q, {31'd0, win_timer});
      win_base     = sum_events;
      win_timer    = win_timer - win_len_us;
      r.window_done = 1'b1;
    end
    w = (inst > ema_rate) ? up_weight : down_weight;
    if (w > W_ONE) w = W_ONE;
    acc = {80'd0, inst} * w + {80'd0, ema_rate} * (W_ONE - w) + 128'd32768;
    ema_rate = acc[63:16];
    r.sample_rate   = inst;
    r.window_rate   = win_rate_q;
    r.window_events = win_events_q;
    r.mean_rate     = rate_fix(sum_events, sum_time_us);
    r.smoothed_rate = ema_rate;
    r.total_events  = sum_events;
    return r;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    case ($urandom_range(0, 9))
      0: it.elapsed_us = 32'd0;
      1: it.elapsed_us = $urandom_range(1, 16);
      7: it.elapsed_us = $urandom;
      8: it.elapsed_us = 32'hFFFF_FFFF - $urandom_range(0, 15);
      9: it.elapsed_us = $urandom_range(1, 2000000);
      default: it.elapsed_us = $urandom_range(1000, 300000);
    endcase
    case ($urandom_range(0, 5))
      0: it.event_count = 32'd0;
      1: it.event_count = 32'hFFFF_FFFF;
      2, 3: it.event_count = $urandom_range(0, 100);
      default: it.event_count = $urandom;
    endcase
    return it;
  endfunction

  // sender: bursts of random length, random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_item    <= '0;
      gap_left   = 0;
      burst_left = 20;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(meter_step(in_item));
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating stall pattern plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      cyc       = 0;
    end else begin
      cyc++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen == 300) begin
        hold_done = 1'b1;
        hold_left = 3000;
        out_stall <= 1'b1;
      end else begin
        case ((cyc / 1000) % 3)
          0: out_stall <= 1'b0;
          1: out_stall <= $urandom_range(0, 1);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_item.sample_rate !== e.sample_rate) begin
          $error("sample_rate exp %0d got %0d", e.sample_rate, out_item.sample_rate);
          errors++;
        end
        if (out_item.window_rate !== e.window_rate) begin
          $error("window_rate exp %0d got %0d", e.window_rate, out_item.window_rate);
          errors++;
        end
        if (out_item.window_events !== e.window_events) begin
          $error("window_events exp %0d got %0d", e.window_events, out_item.window_events);
          errors++;
        end
        if (out_item.window_done !== e.window_done) begin
          $error("window_done exp %0d got %0d", e.window_done, out_item.window_done);
          errors++;
        end
        if (out_item.mean_rate !== e.mean_rate) begin
          $error("mean_rate exp %0d got %0d", e.mean_rate, out_item.mean_rate);
          errors++;
        end
        if (out_item.smoothed_rate !== e.smoothed_rate) begin
          $error("smoothed_rate exp %0d got %0d", e.smoothed_rate, out_item.smoothed_rate);
          errors++;
        end
        if (out_item.total_events !== e.total_events) begin
          $error("total_events exp %0d got %0d", e.total_events, out_item.total_events);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("event_rate_meter_smoothed: mismatch");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_IDX_WINDOW: win_len_us = val;
      CFG_IDX_RISE:   up_weight = val[16:0];
      CFG_IDX_FALL:   down_weight = val[16:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_item(logic [31:0] el, logic [31:0] ev);
    in_item_t it;
    it.elapsed_us  = el;
    it.event_count = ev;
    pending_items.push_back(it);
  endtask

  task automatic push_random(int n);
    repeat (n) pending_items.push_back(random_item());
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_IDX_WINDOW;
    cfg_data    = '0;
    errors      = 0;
    results_seen = 0;
    idle_cycles = 0;
    win_len_us  = WINDOW_RESET;
    up_weight   = WEIGHT_RESET;
    down_weight = WEIGHT_RESET;
    sum_events  = '0;
    sum_time_us = '0;
    win_timer   = '0;
    win_base    = '0;
    win_rate_q  = '0;
    win_events_q = '0;
    ema_rate    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni = 1'b1;

    // zero interval: every item closes, timer never shrinks and saturates
    reg_write(CFG_IDX_WINDOW, 32'd0);
    push_item(32'd0, 32'd3);
    push_item(32'd0, 32'd0);
    push_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_item(32'hFFFF_FFFF, 32'd1);
    push_item(32'hFFFF_FFFF, 32'd7);
    push_random(150);
    drain();

    // defaults again, directed corners
    reg_write(CFG_IDX_WINDOW, WINDOW_RESET);
    push_item(32'd5, 32'd0);
    push_item(32'd1, 32'hFFFF_FFFF);
    push_item(32'hFFFF_FFFF, 32'd1);
    push_item(32'd1000000, 32'd1000);
    push_item(32'd999999, 32'd1);
    push_item(32'd1, 32'd1);
    push_item(32'd2, 32'd0);
    push_item(32'd500000, 32'd10);
    push_random(300);
    drain();

    // one-microsecond window, instant-follow on rise, frozen on fall
    reg_write(CFG_IDX_WINDOW, 32'd1);
    reg_write(CFG_IDX_RISE, 32'd65536);
    reg_write(CFG_IDX_FALL, 32'd0);
    push_item(32'd0, 32'd9);
    push_item(32'd3, 32'd9);
    push_random(200);
    drain();

    // longest window, weights above one clamp; out of range index is dropped
    reg_write(CFG_IDX_WINDOW, 32'hFFFF_FFFF);
    reg_write(CFG_IDX_RISE, 32'd0);
    reg_write(CFG_IDX_FALL, 32'h1_FFFF);
    reg_write(CFG_IDX_NONE, 32'd12345);
    push_random(150);
    drain();

    repeat (2) begin
      reg_write(CFG_IDX_WINDOW, $urandom_range(1, 5000000));
      reg_write(CFG_IDX_RISE, $urandom_range(0, 65536));
      reg_write(CFG_IDX_FALL, $urandom_range(0, 65536));
      push_random(200);
      drain();
    end

    repeat (400) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("event_rate_meter_smoothed: match");
    end else begin
      $display("event_rate_meter_smoothed: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/erm_pkg.sv
src/erm_div.sv
src/erm_ctrl.sv
src/erm_datapath.sv
src/event_rate_meter_smoothed.sv
tb/tb_event_rate_meter_smoothed.sv
